FILE: design/planar_odometry_integrator_assert.svh
// assertion macros for the planar odometry integrator checker
// expects signals aclk and aresetn in the scope of each use
`ifndef PLANAR_ODOMETRY_INTEGRATOR_ASSERT_SVH
`define PLANAR_ODOMETRY_INTEGRATOR_ASSERT_SVH

// consequent checked in the same cycle as the antecedent
`define POI_ASSERT_SAME(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// consequent checked in the cycle after the antecedent
`define POI_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: design/poi_pkg.sv
// shared types, codes and constants of the planar odometry integrator
// no dependencies
package poi_pkg;

    // item kinds carried on s_tuser
    typedef enum logic [1:0] {
        CMD_YAW   = 2'd0,
        CMD_SPEED = 2'd1,
        CMD_TICK  = 2'd2
    } cmd_code_t;

    // sequencer states
    typedef enum logic [3:0] {
        ST_IDLE,
        ST_REDUCE,
        ST_ROTATE,
        ST_FIX,
        ST_MUL_CC,
        ST_MUL_SS,
        ST_MUL_SC,
        ST_MUL_ST,
        ST_MUL_DX,
        ST_MUL_DY,
        ST_FINISH
    } state_t;

    // operand pairs of the shared multiplier
    typedef enum logic [2:0] {
        MUL_CC,
        MUL_SS,
        MUL_SC,
        MUL_ST,
        MUL_DX,
        MUL_DY
    } mul_sel_t;

    // controller to datapath commands
    typedef struct packed {
        logic     take;
        logic     reduce;
        logic     rotate;
        logic     fix;
        logic     mul_en;
        mul_sel_t mul_sel;
        logic     cap_cc;
        logic     cap_cf;
        logic     cap_sf;
        logic     cap_st;
        logic     upd_x;
        logic     finish;
    } ctl_cmd_t;

    // datapath to controller status
    typedef struct packed {
        logic cordic_last;
        logic out_free;
    } ctl_stat_t;

    localparam int SAMPLE_W     = 16;
    localparam int TSTEP_W      = 16;
    localparam int ANG_W        = 34;
    localparam int CRD_W        = 34;
    localparam int TRIG_W       = 32;
    localparam int PROD_W       = 64;
    localparam int OUT_W        = 112;
    localparam int ATAN_IDX_W   = 5;

    localparam logic [TSTEP_W-1:0] TSTEP_RESET = 16'd6554;

    // angles in q28 radians
    localparam logic signed [ANG_W-1:0] ANG_PI      = 34'sd843314857;
    localparam logic signed [ANG_W-1:0] ANG_TWO_PI  = 34'sd1686629713;
    localparam logic signed [ANG_W-1:0] ANG_HALF_PI = 34'sd421657428;

    // converged cordic gain and unity, q30
    localparam logic signed [CRD_W-1:0]  GAIN_Q30 = 34'sd652032874;
    localparam logic signed [PROD_W-1:0] ONE_Q30  = 64'sd1073741824;

    // arctangent of 2^-i in q28
    function automatic logic signed [ANG_W-1:0] atan_q28(input logic [ATAN_IDX_W-1:0] idx);
        logic signed [ANG_W-1:0] v;
        case (idx)
            5'd0:    v = 34'sd210828714;
            5'd1:    v = 34'sd124459457;
            5'd2:    v = 34'sd65760959;
            5'd3:    v = 34'sd33381290;
            5'd4:    v = 34'sd16755422;
            5'd5:    v = 34'sd8385879;
            5'd6:    v = 34'sd4193963;
            5'd7:    v = 34'sd2097109;
            5'd8:    v = 34'sd1048571;
            5'd9:    v = 34'sd524287;
            5'd10:   v = 34'sd262144;
            5'd11:   v = 34'sd131072;
            5'd12:   v = 34'sd65536;
            5'd13:   v = 34'sd32768;
            5'd14:   v = 34'sd16384;
            5'd15:   v = 34'sd8192;
            5'd16:   v = 34'sd4096;
            5'd17:   v = 34'sd2048;
            5'd18:   v = 34'sd1024;
            5'd19:   v = 34'sd512;
            5'd20:   v = 34'sd256;
            5'd21:   v = 34'sd128;
            5'd22:   v = 34'sd64;
            5'd23:   v = 34'sd32;
            default: v = '0;
        endcase
        return v;
    endfunction

endpackage

FILE: design/poi_ctrl.sv
// sequencer of the planar odometry integrator
// depends on poi_pkg; drives poi_dpath through ctl_cmd_t
module poi_ctrl
    import poi_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    input  logic [1:0]  s_tuser,
    output logic        s_tready,
    input  ctl_stat_t   stat,
    output ctl_cmd_t    cmd
);

    state_t state_reg;
    state_t state_next;

    // state register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    // next state and commands
    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        s_tready   = 1'b0;
        case (state_reg)
            ST_IDLE: begin
                s_tready = 1'b1;
                cmd.take = s_tvalid;
                if (s_tvalid && s_tuser == CMD_TICK) begin
                    state_next = ST_REDUCE;
                end
            end
            ST_REDUCE: begin
                cmd.reduce = 1'b1;
                state_next = ST_ROTATE;
            end
            ST_ROTATE: begin
                cmd.rotate = 1'b1;
                if (stat.cordic_last) begin
                    state_next = ST_FIX;
                end
            end
            ST_FIX: begin
                cmd.fix    = 1'b1;
                state_next = ST_MUL_CC;
            end
            ST_MUL_CC: begin
                cmd.mul_en  = 1'b1;
                cmd.mul_sel = MUL_CC;
                state_next  = ST_MUL_SS;
            end
            ST_MUL_SS: begin
                cmd.mul_en  = 1'b1;
                cmd.mul_sel = MUL_SS;
                cmd.cap_cc  = 1'b1;
                state_next  = ST_MUL_SC;
            end
            ST_MUL_SC: begin
                cmd.mul_en  = 1'b1;
                cmd.mul_sel = MUL_SC;
                cmd.cap_cf  = 1'b1;
                state_next  = ST_MUL_ST;
            end
            ST_MUL_ST: begin
                cmd.mul_en  = 1'b1;
                cmd.mul_sel = MUL_ST;
                cmd.cap_sf  = 1'b1;
                state_next  = ST_MUL_DX;
            end
            ST_MUL_DX: begin
                cmd.mul_en  = 1'b1;
                cmd.mul_sel = MUL_DX;
                cmd.cap_st  = 1'b1;
                state_next  = ST_MUL_DY;
            end
            ST_MUL_DY: begin
                cmd.mul_en  = 1'b1;
                cmd.mul_sel = MUL_DY;
                cmd.upd_x   = 1'b1;
                state_next  = ST_FINISH;
            end
            ST_FINISH: begin
                // wait for the output register to free up
                if (stat.out_free) begin
                    cmd.finish = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

FILE: design/poi_dpath.sv
// datapath of the planar odometry integrator: state, cordic, multiplier, output register
// depends on poi_pkg; sequenced by poi_ctrl
module poi_dpath
    import poi_pkg::*;
#(
    parameter int CORDIC_STEPS   = 16,
    parameter int POSITION_WIDTH = 32
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  ctl_cmd_t            cmd,
    output ctl_stat_t           stat,
    input  logic [SAMPLE_W-1:0] sample,
    input  logic [1:0]          kind,
    input  logic                cfg_wr_en,
    input  logic [TSTEP_W-1:0]  cfg_wr_data,
    input  logic                m_tready,
    output logic                m_tvalid,
    output logic [OUT_W-1:0]    m_tdata
);

    localparam int CW = (CORDIC_STEPS > 1) ? $clog2(CORDIC_STEPS) : 1;
    localparam int DW = 26;
    localparam int SW = ((POSITION_WIDTH > DW) ? POSITION_WIDTH : DW) + 1;
    localparam logic signed [SW-1:0] ACC_MAX =
        SW'((64'sd1 <<< (POSITION_WIDTH - 1)) - 64'sd1);
    localparam logic signed [SW-1:0] ACC_MIN = ~ACC_MAX;

    // architectural state
    logic [TSTEP_W-1:0]              time_step_reg;
    logic [SAMPLE_W-1:0]             ref_reg;
    logic signed [SAMPLE_W:0]        rel_reg;
    logic signed [SAMPLE_W-1:0]      speed_reg;
    logic signed [POSITION_WIDTH-1:0] acc_x_reg;
    logic signed [POSITION_WIDTH-1:0] acc_y_reg;

    // working registers
    logic signed [ANG_W-1:0]  ang_reg;
    logic signed [CRD_W-1:0]  x_reg;
    logic signed [CRD_W-1:0]  y_reg;
    logic                     neg_reg;
    logic [CW-1:0]            iter_reg;
    logic signed [TRIG_W-1:0] c_reg;
    logic signed [TRIG_W-1:0] s_reg;
    logic signed [PROD_W-1:0] prod_reg;
    logic signed [PROD_W-1:0] cc_reg;
    logic signed [TRIG_W-1:0] cf_reg;
    logic signed [TRIG_W-1:0] sf_reg;
    logic signed [TRIG_W-1:0] st_reg;

    // output register
    logic                     out_valid_reg;
    logic [OUT_W-1:0]         out_data_reg;

    logic signed [SAMPLE_W-1:0] smp;
    assign smp = signed'(sample);

    // unity-clamped q30 from a shifted product
    function automatic logic signed [TRIG_W-1:0] clamp_q30(input logic signed [PROD_W-1:0] v);
        logic signed [PROD_W-1:0] r;
        r = v;
        if (v > ONE_Q30) begin
            r = ONE_Q30;
        end else if (v < -ONE_Q30) begin
            r = -ONE_Q30;
        end
        return TRIG_W'(r);
    endfunction

    // round q54 step to q16 and add with saturation
    function automatic logic signed [POSITION_WIDTH-1:0] sat_add(
        input logic signed [POSITION_WIDTH-1:0] acc,
        input logic signed [PROD_W-1:0]         p
    );
        logic signed [PROD_W-1:0] r;
        logic signed [DW-1:0]     d;
        logic signed [SW-1:0]     sum;
        r   = (p + (64'sd1 <<< 37)) >>> 38;
        d   = signed'(r[DW-1:0]);
        sum = SW'(acc) + SW'(d);
        if (sum > ACC_MAX) begin
            sum = ACC_MAX;
        end else if (sum < ACC_MIN) begin
            sum = ACC_MIN;
        end
        return POSITION_WIDTH'(sum);
    endfunction

    // q30 to q14 with round half up and clamp
    function automatic logic [15:0] to_q14(input logic signed [TRIG_W-1:0] v);
        logic signed [TRIG_W:0]   t;
        logic signed [TRIG_W-16:0] q;
        t = (TRIG_W+1)'(v) + 33'sd32768;
        q = (TRIG_W-15)'(t >>> 16);
        if (q > 17'sd16384) begin
            q = 17'sd16384;
        end else if (q < -17'sd16384) begin
            q = -17'sd16384;
        end
        return q[15:0];
    endfunction

    // range reduction into [-pi/2, pi/2]
    logic signed [ANG_W-1:0] red_a0;
    logic signed [ANG_W-1:0] red_a1;
    logic signed [ANG_W-1:0] red_a2;
    logic                    red_neg;

    always_comb begin
        red_a0  = ANG_W'(rel_reg) <<< 15;
        red_a1  = red_a0;
        if (red_a0 > ANG_PI) begin
            red_a1 = red_a0 - ANG_TWO_PI;
        end else if (red_a0 < -ANG_PI) begin
            red_a1 = red_a0 + ANG_TWO_PI;
        end
        red_a2  = red_a1;
        red_neg = 1'b0;
        if (red_a1 > ANG_HALF_PI) begin
            red_a2  = red_a1 - ANG_PI;
            red_neg = 1'b1;
        end else if (red_a1 < -ANG_HALF_PI) begin
            red_a2  = red_a1 + ANG_PI;
            red_neg = 1'b1;
        end
    end

    // one cordic rotation step
    logic signed [CRD_W-1:0] rot_xs;
    logic signed [CRD_W-1:0] rot_ys;
    logic signed [ANG_W-1:0] rot_at;

    assign rot_xs = x_reg >>> iter_reg;
    assign rot_ys = y_reg >>> iter_reg;
    assign rot_at = atan_q28(ATAN_IDX_W'(iter_reg));

    // shared multiplier operand select
    logic signed [TRIG_W-1:0] mul_a;
    logic signed [TRIG_W-1:0] mul_b;
    logic signed [PROD_W-1:0] mul_p;

    always_comb begin
        case (cmd.mul_sel)
            MUL_CC: begin
                mul_a = c_reg;
                mul_b = c_reg;
            end
            MUL_SS: begin
                mul_a = s_reg;
                mul_b = s_reg;
            end
            MUL_SC: begin
                mul_a = s_reg;
                mul_b = c_reg;
            end
            MUL_ST: begin
                mul_a = TRIG_W'(speed_reg);
                mul_b = signed'(TRIG_W'(time_step_reg));
            end
            MUL_DX: begin
                mul_a = signed'(prod_reg[TRIG_W-1:0]);
                mul_b = cf_reg;
            end
            MUL_DY: begin
                mul_a = st_reg;
                mul_b = sf_reg;
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    assign mul_p = mul_a * mul_b;

    // new y position and sign-extended views of the accumulators
    logic signed [POSITION_WIDTH-1:0] acc_y_next;
    logic signed [63:0]               acc_x_ext;
    logic signed [63:0]               acc_y_ext;

    assign acc_y_next = sat_add(acc_y_reg, prod_reg);
    assign acc_x_ext  = 64'(acc_x_reg);
    assign acc_y_ext  = 64'(acc_y_next);

    // configuration and architectural state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            time_step_reg <= TSTEP_RESET;
            ref_reg       <= '0;
            rel_reg       <= '0;
            speed_reg     <= '0;
            acc_x_reg     <= '0;
            acc_y_reg     <= '0;
        end else begin
            if (cfg_wr_en) begin
                time_step_reg <= cfg_wr_data;
            end
            if (cmd.take) begin
                case (kind)
                    CMD_YAW: begin
                        if (ref_reg == '0) begin
                            ref_reg <= sample;
                            rel_reg <= '0;
                        end else begin
                            rel_reg <= (SAMPLE_W+1)'(smp)
                                     - (SAMPLE_W+1)'(signed'(ref_reg));
                        end
                    end
                    CMD_SPEED: begin
                        speed_reg <= smp;
                    end
                    default: begin
                    end
                endcase
            end
            if (cmd.upd_x) begin
                acc_x_reg <= sat_add(acc_x_reg, prod_reg);
            end
            if (cmd.finish) begin
                acc_y_reg <= acc_y_next;
            end
        end
    end

    // cordic, multiplier and trig working registers
    always_ff @(posedge aclk) begin
        if (cmd.reduce) begin
            ang_reg  <= red_a2;
            neg_reg  <= red_neg;
            x_reg    <= GAIN_Q30;
            y_reg    <= '0;
        end else if (cmd.rotate) begin
            if (!ang_reg[ANG_W-1]) begin
                x_reg   <= x_reg - rot_ys;
                y_reg   <= y_reg + rot_xs;
                ang_reg <= ang_reg - rot_at;
            end else begin
                x_reg   <= x_reg + rot_ys;
                y_reg   <= y_reg - rot_xs;
                ang_reg <= ang_reg + rot_at;
            end
        end
        if (cmd.fix) begin
            c_reg <= neg_reg ? TRIG_W'(-x_reg) : TRIG_W'(x_reg);
            s_reg <= neg_reg ? TRIG_W'(-y_reg) : TRIG_W'(y_reg);
        end
        if (cmd.mul_en) begin
            prod_reg <= mul_p;
        end
        if (cmd.cap_cc) begin
            cc_reg <= prod_reg;
        end
        if (cmd.cap_cf) begin
            cf_reg <= clamp_q30((cc_reg - prod_reg) >>> 30);
        end
        if (cmd.cap_sf) begin
            sf_reg <= clamp_q30(prod_reg >>> 29);
        end
        if (cmd.cap_st) begin
            st_reg <= signed'(prod_reg[TRIG_W-1:0]);
        end
        if (cmd.finish) begin
            out_data_reg <= {speed_reg, to_q14(c_reg), to_q14(s_reg),
                             acc_y_ext[31:0], acc_x_ext[31:0]};
        end
    end

    // rotation step counter
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            iter_reg <= '0;
        end else if (cmd.reduce) begin
            iter_reg <= '0;
        end else if (cmd.rotate) begin
            iter_reg <= iter_reg + CW'(1);
        end
    end

    // output valid
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (cmd.finish) begin
            out_valid_reg <= 1'b1;
        end else if (m_tready) begin
            out_valid_reg <= 1'b0;
        end
    end

    assign stat.cordic_last = (iter_reg == CW'(CORDIC_STEPS - 1));
    assign stat.out_free    = !out_valid_reg || m_tready;
    assign m_tvalid         = out_valid_reg;
    assign m_tdata          = out_data_reg;

endmodule

FILE: design/planar_odometry_integrator.sv
// top level of the planar odometry integrator
// depends on poi_pkg, poi_ctrl and poi_dpath
//
// usage:
//   s_ channel: one transaction per item; s_tuser is the item kind (yaw sample,
//   speed sample, update tick), s_tdata the sample. yaw and speed samples are
//   taken while idle and give no result. a tick runs range reduction, a
//   CORDIC_STEPS-iteration cordic, and six products on one shared 32x32
//   multiplier, then loads one result into the output register.
//   while a tick is worked, s_tready stays low and no further item is taken;
//   the next item is taken after the result is loaded into the output register.
//   m_ channel: result held in an output register; while it waits for m_tready
//   the block takes further samples, and a following tick holds in its last
//   step until the register frees.
//   cfg_wr_en / cfg_wr_data write time_step at any edge.
//   reset (aresetn low, synchronous) clears heading, speed and position,
//   sets time_step to 0.1 s and drops m_tvalid.
module planar_odometry_integrator
    import poi_pkg::*;
#(
    parameter int CORDIC_STEPS   = 16,
    parameter int POSITION_WIDTH = 32
) (
    input  logic                aclk,
    input  logic                aresetn,
    // input channel
    input  logic                s_tvalid,
    output logic                s_tready,
    input  logic [15:0]         s_tdata,   // [15:0] sample_value
    input  logic [1:0]          s_tuser,   // [1:0] command
    // result channel
    output logic                m_tvalid,
    input  logic                m_tready,
    output logic [111:0]        m_tdata,   // [31:0] position_x, [63:32] position_y,
                                           // [79:64] orientation_z,
                                           // [95:80] orientation_w,
                                           // [111:96] linear_speed
    // configuration
    input  logic                cfg_wr_en,
    input  logic [15:0]         cfg_wr_data
);

    ctl_cmd_t  cmd;
    ctl_stat_t stat;

    // sequencer
    poi_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tuser  (s_tuser),
        .s_tready (s_tready),
        .stat     (stat),
        .cmd      (cmd)
    );

    // datapath
    poi_dpath #(
        .CORDIC_STEPS   (CORDIC_STEPS),
        .POSITION_WIDTH (POSITION_WIDTH)
    ) u_dpath (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cmd         (cmd),
        .stat        (stat),
        .sample      (s_tdata),
        .kind        (s_tuser),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .m_tready    (m_tready),
        .m_tvalid    (m_tvalid),
        .m_tdata     (m_tdata)
    );

endmodule

FILE: design/poi_checker.sv
// port-level checker of the planar odometry integrator, bound to the top level
// depends on poi_pkg and planar_odometry_integrator_assert.svh
`include "planar_odometry_integrator_assert.svh"

module poi_checker
    import poi_pkg::*;
(
    input logic         aclk,
    input logic         aresetn,
    input logic         s_tvalid,
    input logic         s_tready,
    input logic [1:0]   s_tuser,
    input logic         m_tvalid,
    input logic         m_tready,
    input logic [111:0] m_tdata
);

    // a stalled result stays offered
    `POI_ASSERT_NEXT(a_out_hold, m_tvalid && !m_tready, m_tvalid, "result dropped while stalled")

    // a stalled result keeps its payload
    `POI_ASSERT_NEXT(a_out_stable, m_tvalid && !m_tready, $stable(m_tdata), "result changed while stalled")

    // a tick transaction occupies the block
    `POI_ASSERT_NEXT(a_tick_busy, s_tvalid && s_tready && s_tuser == CMD_TICK, !s_tready, "input taken during tick work")

    // samples never produce a result
    `POI_ASSERT_NEXT(a_sample_quiet, s_tvalid && s_tready && s_tuser != CMD_TICK && !m_tvalid, !m_tvalid, "result after a sample")

endmodule

bind planar_odometry_integrator poi_checker u_poi_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);
